[rtl/two_channel_fringe_density_tracker_assert.svh]
// Assertion macros shared by the fringe tracker modules.
`ifndef TWO_CHANNEL_FRINGE_DENSITY_TRACKER_ASSERT_SVH
`define TWO_CHANNEL_FRINGE_DENSITY_TRACKER_ASSERT_SVH

// Condition holds at every edge out of reset.
`define TDT_ASSERT_HOLDS(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tdt: invariant violated");

// Same-cycle implication.
`define TDT_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tdt: implication violated");

// Next-cycle implication.
`define TDT_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tdt: next-cycle check violated");

`endif

[rtl/tdt_pkg.sv]
package tdt_pkg;

  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_CH0_QUAD  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CH0_LIN   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CH0_CONST = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CH1_QUAD  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CH1_LIN   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CH1_CONST = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_UPPER     = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_LOWER     = 3'd7;

  typedef struct packed {
    logic signed [31:0] ch0_quad;
    logic signed [31:0] ch0_lin;
    logic signed [31:0] ch0_const;
    logic signed [31:0] ch1_quad;
    logic signed [31:0] ch1_lin;
    logic signed [31:0] ch1_const;
  } tdt_coef_t;

  typedef struct packed {
    logic signed [31:0] upper;
    logic signed [31:0] lower;
  } tdt_limit_t;

  // One classified item between front and back.
  typedef struct packed {
    logic signed [31:0] val0;
    logic signed [31:0] val1;
    logic               last;
    logic               preset;
    logic               preset_channel;
    logic signed [31:0] preset_offset;
  } tdt_entry_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/two_channel_fringe_density_tracker.sv]
// Two-channel fringe density tracker.
// Input channel: item_valid / item_stall carry one pair of ADC codes plus block
// and preset flags; an item is taken on a clock edge with valid high, stall low.
// Result channel: result_valid / result_stall carry one result per item:
// density, channel used, jump kind, and the block mean on a block's last item.
// Config: cfg_write with cfg_index / cfg_data writes one register per edge;
// write only while the block is idle.
// The front end's single shared multiplier forms the square, quad and linear
// product for each of the two channels in turn; the front takes no new item
// until the current one is pushed into the queue. An item that closes a block
// also runs the mean divider (B_DIV) and then the hand-off state (B_WAIT)
// before its result is loaded.
// A two-entry queue sits between front and back, and the result register
// lets the front take new items while a result waits on result_stall.
// Reset (rst, synchronous) clears the config registers to zero and sets channel 0,
// offset 0, an empty block and an empty queue; nothing waits after reset.
module two_channel_fringe_density_tracker #(
  parameter int HALF_FRINGE = 32768,
  parameter int BLOCK_MAX   = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [15:0]         raw_ch0,
  input  logic [15:0]         raw_ch1,
  input  logic                last_in_block,
  input  logic                preset,
  input  logic                preset_channel,
  input  logic signed [31:0]  preset_offset,
  output logic                result_valid,
  input  logic                result_stall,
  output logic signed [31:0]  density,
  output logic                channel_used,
  output logic [1:0]          jump_kind,
  output logic signed [31:0]  block_mean,
  output logic                mean_valid
);
  import tdt_pkg::*;

  tdt_coef_t  coef;
  tdt_limit_t lim;

  // queue wiring
  logic       q_push, q_full, q_pop, q_valid;
  tdt_entry_t q_din, q_dout;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
      lim  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CH0_QUAD:  coef.ch0_quad  <= cfg_data;
        REG_CH0_LIN:   coef.ch0_lin   <= cfg_data;
        REG_CH0_CONST: coef.ch0_const <= cfg_data;
        REG_CH1_QUAD:  coef.ch1_quad  <= cfg_data;
        REG_CH1_LIN:   coef.ch1_lin   <= cfg_data;
        REG_CH1_CONST: coef.ch1_const <= cfg_data;
        REG_UPPER:     lim.upper      <= cfg_data;
        REG_LOWER:     lim.lower      <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: voltage conversion and both channel quadratics
  tdt_front u_front (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .raw_ch0        (raw_ch0),
    .raw_ch1        (raw_ch1),
    .last_in_block  (last_in_block),
    .preset         (preset),
    .preset_channel (preset_channel),
    .preset_offset  (preset_offset),
    .coef           (coef),
    .q_push         (q_push),
    .q_data         (q_din),
    .q_full         (q_full)
  );

  tdt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .din     (q_din),
    .full    (q_full),
    .pop     (q_pop),
    .dout    (q_dout),
    .q_valid (q_valid)
  );

  // back: fringe tracking, block sum, mean divider, result register
  tdt_back #(
    .HALF_FRINGE (HALF_FRINGE),
    .BLOCK_MAX   (BLOCK_MAX)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .lim          (lim),
    .q_valid      (q_valid),
    .q_data       (q_dout),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .density      (density),
    .channel_used (channel_used),
    .jump_kind    (jump_kind),
    .block_mean   (block_mean),
    .mean_valid   (mean_valid)
  );

endmodule

[rtl/tdt_front.sv]
module tdt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [15:0]         raw_ch0,
  input  logic [15:0]         raw_ch1,
  input  logic                last_in_block,
  input  logic                preset,
  input  logic                preset_channel,
  input  logic signed [31:0]  preset_offset,
  input  tdt_pkg::tdt_coef_t  coef,
  output logic                q_push,
  output tdt_pkg::tdt_entry_t q_data,
  input  logic                q_full
);
  import tdt_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_CALC, F_PUSH} fstate_t;

  localparam logic [2:0] SUB_SQ  = 3'd0;
  localparam logic [2:0] SUB_QV  = 3'd1;
  localparam logic [2:0] SUB_LV  = 3'd2;
  localparam logic [2:0] SUB_ADD = 3'd3;
  localparam logic [2:0] SUB_RND = 3'd4;

  fstate_t            state;
  logic [2:0]         sub;
  logic               ch;
  logic signed [23:0] volt0, volt1;
  logic signed [63:0] prod, acc;
  logic signed [31:0] val0, val1;
  logic               last_r, preset_r, pch_r;
  logic signed [31:0] poff_r;

  logic signed [23:0] vsel;
  logic [22:0]        mag;
  logic signed [31:0] cq, cl, cc;
  logic signed [63:0] v2w, rnd;
  logic [26:0]        v2;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  // code -> Q5.18 volts; /65535 done as high+low fold with one correction
  function automatic logic signed [23:0] to_volt(input logic [15:0] raw);
    logic [22:0] x, y;
    logic [16:0] s;
    logic [6:0]  q;
    x = {1'b0, raw, 6'b0} + {3'b0, raw, 4'b0};
    y = x + 23'd32767;
    s = {10'b0, y[22:16]} + {1'b0, y[15:0]};
    q = y[22:16] + ((s >= 17'd65535) ? 7'd1 : 7'd0);
    return $signed({1'b0, x}) + $signed({17'b0, q}) - 24'sd2621440;
  endfunction

  assign vsel  = ch ? volt1 : volt0;
  assign mag   = vsel[23] ? 23'(-vsel) : vsel[22:0];
  assign cq    = ch ? coef.ch1_quad  : coef.ch0_quad;
  assign cl    = ch ? coef.ch1_lin   : coef.ch0_lin;
  assign cc    = ch ? coef.ch1_const : coef.ch0_const;
  assign v2w   = prod + 64'sd131072;
  assign v2    = v2w[44:18];
  assign rnd   = acc + 64'sd131072;
  assign mul_p = mul_a * mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (sub)
      SUB_SQ: begin
        mul_a = $signed({10'b0, mag});
        mul_b = $signed({10'b0, mag});
      end
      SUB_QV: begin
        mul_a = 33'(cq);
        mul_b = $signed({6'b0, v2});
      end
      SUB_LV: begin
        mul_a = 33'(cl);
        mul_b = 33'(vsel);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign item_stall = (state != F_IDLE);
  assign q_push     = (state == F_PUSH) && !q_full;
  assign q_data     = '{val0: val0, val1: val1, last: last_r, preset: preset_r,
                        preset_channel: pch_r, preset_offset: poff_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      sub   <= SUB_SQ;
      ch    <= 1'b0;
    end else begin
      case (state)
        F_IDLE: begin
          if (item_valid) begin
            volt0    <= to_volt(raw_ch0);
            volt1    <= to_volt(raw_ch1);
            last_r   <= last_in_block;
            preset_r <= preset;
            pch_r    <= preset_channel;
            poff_r   <= preset_offset;
            sub      <= SUB_SQ;
            ch       <= 1'b0;
            state    <= F_CALC;
          end
        end
        F_CALC: begin
          prod <= mul_p[63:0];
          case (sub)
            SUB_SQ: sub <= SUB_QV;
            SUB_QV: begin
              acc <= 64'(cc) <<< 18;
              sub <= SUB_LV;
            end
            SUB_LV: begin
              acc <= acc + prod;
              sub <= SUB_ADD;
            end
            SUB_ADD: begin
              acc <= acc + prod;
              sub <= SUB_RND;
            end
            SUB_RND: begin
              if (ch) begin
                val1  <= sat32(rnd >>> 18);
                state <= F_PUSH;
              end else begin
                val0 <= sat32(rnd >>> 18);
                ch   <= 1'b1;
              end
              sub <= SUB_SQ;
            end
            default: sub <= SUB_SQ;
          endcase
        end
        F_PUSH: begin
          if (!q_full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

[rtl/tdt_queue.sv]
`include "two_channel_fringe_density_tracker_assert.svh"

module tdt_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tdt_pkg::tdt_entry_t din,
  output logic                full,
  input  logic                pop,
  output tdt_pkg::tdt_entry_t dout,
  output logic                q_valid
);
  import tdt_pkg::*;

  localparam int DEPTH = 2;

  tdt_entry_t  mem [DEPTH];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  cnt;

  assign full    = (cnt == 2'(DEPTH));
  assign q_valid = (cnt != 2'd0);
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      cnt <= cnt + 2'd1;
      else if (pop && !push) cnt <= cnt - 2'd1;
    end
  end

  `TDT_ASSERT_HOLDS(a_cnt_bound, clk, rst, cnt <= 2'(DEPTH))
  `TDT_ASSERT_NEXT(a_cnt_up, clk, rst, push && !pop, cnt == $past(cnt) + 2'd1)
  `TDT_ASSERT_NEXT(a_cnt_down, clk, rst, pop && !push, cnt == $past(cnt) - 2'd1)

endmodule

[rtl/tdt_back.sv]
`include "two_channel_fringe_density_tracker_assert.svh"

module tdt_back #(
  parameter int HALF_FRINGE = 32768,
  parameter int BLOCK_MAX   = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  tdt_pkg::tdt_limit_t lim,
  input  logic                q_valid,
  input  tdt_pkg::tdt_entry_t q_data,
  output logic                q_pop,
  output logic                result_valid,
  input  logic                result_stall,
  output logic signed [31:0]  density,
  output logic                channel_used,
  output logic [1:0]          jump_kind,
  output logic signed [31:0]  block_mean,
  output logic                mean_valid
);
  import tdt_pkg::*;

  localparam int CNT_W  = $clog2(BLOCK_MAX + 1);
  localparam int SUM_W  = 32 + CNT_W;
  localparam int NUM_W  = SUM_W + 1;
  localparam int DCNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0]  BMAX  = CNT_W'(BLOCK_MAX);
  localparam logic [DCNT_W-1:0] DLAST = DCNT_W'(NUM_W - 1);
  localparam logic signed [63:0] HF   = 64'(HALF_FRINGE);

  typedef enum logic [1:0] {B_RUN, B_DIV, B_WAIT} bstate_t;

  bstate_t                  state;
  logic                     active_channel;
  logic signed [31:0]       fringe_offset;
  logic signed [SUM_W-1:0]  block_sum;
  logic [CNT_W-1:0]         block_count;

  logic signed [31:0]       pend_density;
  logic                     pend_channel;
  logic [1:0]               pend_kind;
  logic                     neg;
  logic [NUM_W-1:0]         dnum;
  logic [CNT_W-1:0]         drem, dn;
  logic [DCNT_W-1:0]        dcnt;

  logic                     out_free;
  logic                     res_load;
  logic                     ch, up, dn_hit, nxt;
  logic signed [31:0]       off, off1, off2, cur, dens;
  logic signed [SUM_W-1:0]  sum_new;
  logic [CNT_W-1:0]         cnt_new, n_div;
  logic [SUM_W-1:0]         mag;
  logic [CNT_W:0]           trial;
  logic                     ge;
  logic signed [NUM_W:0]    qs;
  logic signed [31:0]       mean_sat;

  assign out_free = !result_valid || !result_stall;
  assign q_pop    = (state == B_RUN) && q_valid && out_free;
  // result register reloads this cycle
  assign res_load = (q_pop && !q_data.last) || ((state == B_WAIT) && out_free);

  // tracking step for the item at the queue head
  always_comb begin
    ch      = q_data.preset ? q_data.preset_channel : active_channel;
    off     = q_data.preset ? q_data.preset_offset  : fringe_offset;
    cur     = ch ? q_data.val1 : q_data.val0;
    up      = cur > lim.upper;
    dn_hit  = cur < lim.lower;
    off1    = up ? sat32(64'(off) + HF) : off;
    off2    = dn_hit ? sat32(64'(off1) - HF) : off1;
    nxt     = (up || dn_hit) ? ~ch : ch;
    dens    = sat32(64'(off2) + 64'(nxt ? q_data.val1 : q_data.val0));
    if (block_count < BMAX) begin
      sum_new = block_sum + SUM_W'(dens);
      cnt_new = block_count + CNT_W'(1);
    end else begin
      sum_new = block_sum;
      cnt_new = block_count;
    end
    n_div   = (cnt_new == '0) ? CNT_W'(1) : cnt_new;
    mag     = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
  end

  // restoring divider, one quotient bit per cycle
  assign trial = {drem, dnum[NUM_W-1]};
  assign ge    = trial >= {1'b0, dn};
  assign qs    = $signed({1'b0, dnum});
  assign mean_sat = sat32(64'(neg ? -qs : qs));

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= B_RUN;
      active_channel <= 1'b0;
      fringe_offset  <= '0;
      block_sum      <= '0;
      block_count    <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (result_valid && !result_stall && !res_load) result_valid <= 1'b0;
      case (state)
        B_RUN: begin
          if (q_pop) begin
            active_channel <= nxt;
            fringe_offset  <= off2;
            if (q_data.last) begin
              block_sum    <= '0;
              block_count  <= '0;
              pend_density <= dens;
              pend_channel <= nxt;
              pend_kind    <= {dn_hit, up};
              neg          <= sum_new[SUM_W-1];
              dnum         <= {1'b0, mag} + NUM_W'(n_div >> 1);
              drem         <= '0;
              dn           <= n_div;
              dcnt         <= '0;
              state        <= B_DIV;
            end else begin
              block_sum    <= sum_new;
              block_count  <= cnt_new;
              result_valid <= 1'b1;
              density      <= dens;
              channel_used <= nxt;
              jump_kind    <= {dn_hit, up};
              block_mean   <= '0;
              mean_valid   <= 1'b0;
            end
          end
        end
        B_DIV: begin
          drem <= ge ? CNT_W'(trial - {1'b0, dn}) : trial[CNT_W-1:0];
          dnum <= {dnum[NUM_W-2:0], ge};
          dcnt <= dcnt + DCNT_W'(1);
          if (dcnt == DLAST) state <= B_WAIT;
        end
        B_WAIT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            density      <= pend_density;
            channel_used <= pend_channel;
            jump_kind    <= pend_kind;
            block_mean   <= mean_sat;
            mean_valid   <= 1'b1;
            state        <= B_RUN;
          end
        end
        default: state <= B_RUN;
      endcase
    end
  end

  `TDT_ASSERT_HOLDS(a_count_cap, clk, rst, block_count <= BMAX)
  `TDT_ASSERT_IMPL(a_mean_zero, clk, rst, result_valid && !mean_valid, block_mean == '0)
  `TDT_ASSERT_NEXT(a_last_divides, clk, rst, q_pop && q_data.last, state == B_DIV)

endmodule
